>>> hw/rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int DEPTH   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  // Codes and fixed values
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Cursor position as reported on the result channel
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [OFF_W-1:0] offset;
  } cursor_t;

  // Outcome of a put, worked out before it is committed
  typedef struct packed {
    cursor_t cur;
    logic    scroll;
    logic    write_cell;
  } put_plan_t;

endpackage

>>> hw/rtl/tcw_ram.sv
module tcw_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 2000,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tcw_cursor.sv
module tcw_cursor import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              commit,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  read_row,
  input  logic [COL_W-1:0]  read_col,
  output cursor_t           cur,
  output put_plan_t         plan,
  output logic [ADDR_W-1:0] put_addr,
  output logic [ADDR_W-1:0] read_addr,
  output logic              read_ok,
  output logic [ADDR_W-1:0] top_base
);

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] top_r;
  logic [OFF_W-1:0] off_r;
  logic [ROW_W-1:0] top_nxt;

  logic             newline;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W:0]   top_inc;
  logic             adv_row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [ROW_W:0]   put_prow_sum;
  logic [ROW_W-1:0] put_prow;
  logic [ROW_W:0]   rd_prow_sum;
  logic [ROW_W-1:0] rd_prow;

  assign cur = '{col: col_r, row: row_r, offset: off_r};

  // Next cursor for a put
  always_comb begin
    newline  = (char_code == NEWLINE_CODE);
    col_inc  = {1'b0, col_r} + (COL_W+1)'(1);
    row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);
    top_inc  = {1'b0, top_r} + (ROW_W+1)'(1);
    adv_row  = newline || (col_inc == (COL_W+1)'(COLUMNS));
    col_next = adv_row ? '0 : col_inc[COL_W-1:0];
    plan.scroll     = adv_row && (row_inc == (ROW_W+1)'(ROWS));
    plan.write_cell = !newline;
    if (plan.scroll) begin
      row_next = ROW_W'(ROWS - 1);
      top_nxt  = (top_inc == (ROW_W+1)'(ROWS)) ? '0 : top_inc[ROW_W-1:0];
    end else begin
      row_next = adv_row ? row_inc[ROW_W-1:0] : row_r;
      top_nxt  = top_r;
    end
    plan.cur.col    = col_next;
    plan.cur.row    = row_next;
    plan.cur.offset = OFF_W'(row_next) * OFF_W'(COLUMNS) + OFF_W'(col_next);
  end

  // Logical row to physical row; cursor and top rows are below ROWS, a read row need not be (read_ok)
  always_comb begin
    put_prow_sum = {1'b0, row_r} + {1'b0, top_r};
    put_prow     = (put_prow_sum >= (ROW_W+1)'(ROWS)) ?
                   ROW_W'(put_prow_sum - (ROW_W+1)'(ROWS)) : put_prow_sum[ROW_W-1:0];
    put_addr     = ADDR_W'(put_prow) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

    read_ok      = ({1'b0, read_row} < (ROW_W+1)'(ROWS)) &&
                   ({1'b0, read_col} < (COL_W+1)'(COLUMNS));
    rd_prow_sum  = {1'b0, read_row} + {1'b0, top_r};
    rd_prow      = (rd_prow_sum >= (ROW_W+1)'(ROWS)) ?
                   ROW_W'(rd_prow_sum - (ROW_W+1)'(ROWS)) : rd_prow_sum[ROW_W-1:0];
    read_addr    = ADDR_W'(rd_prow) * ADDR_W'(COLUMNS) + ADDR_W'(read_col);

    // Row that becomes the bottom after a scroll is the current top row
    top_base     = ADDR_W'(top_r) * ADDR_W'(COLUMNS);
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      top_r <= '0;
      off_r <= '0;
    end else if (commit) begin
      col_r <= plan.cur.col;
      row_r <= plan.cur.row;
      top_r <= top_nxt;
      off_r <= plan.cur.offset;
    end
  end

endmodule

>>> hw/rtl/text_console_writer.sv
// Channel  | Handshake           | Beat contents
// ---------+---------------------+-----------------------------------------------
// in       | in_valid / in_stall | operation, char_code, read_row, read_col
// out      | out_valid/out_stall | cell_value, cursor_offset/col/row, scrolled
// cfg      | cfg_write_en        | cfg_write_data -> text attribute
//
// Put results are registered; a read first passes the registered screen RAM read port.
// A put that scrolls then blanks the new bottom row one cell a cycle.
// After reset the screen RAM is swept to blanks with in_stall high;
// configuration writes are taken during the sweep.
// in_stall is also high while a result waits on a stalled output.
module text_console_writer import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [ATTR_W-1:0] cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [0:0]        in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic [COL_W-1:0]  in_read_col,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CELL_W-1:0] out_cell_value,
  output logic [OFF_W-1:0]  out_cursor_offset,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic              out_scrolled
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL
  } state_t;

  state_t            state_r;
  logic [ATTR_W-1:0] attr_r;
  logic [ADDR_W-1:0] swp_addr_r;
  logic [ADDR_W-1:0] swp_end_r;
  logic              rd_ok_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] cell_r;
  cursor_t           cur_out_r;
  logic              scrolled_r;

  logic              in_acc;
  logic              is_read;
  logic              commit;
  cursor_t           cur;
  put_plan_t         plan;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] read_addr;
  logic              read_ok;
  logic [ADDR_W-1:0] top_base;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  // Input handshake
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign is_read  = (in_operation == OP_READ);
  assign commit   = in_acc && !is_read;

  tcw_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .char_code (in_char_code),
    .read_row  (in_read_row),
    .read_col  (in_read_col),
    .cur       (cur),
    .plan      (plan),
    .put_addr  (put_addr),
    .read_addr (read_addr),
    .read_ok   (read_ok),
    .top_base  (top_base)
  );

  // Write port: sweeps write blanks, a put other than newline writes attribute:char
  always_comb begin
    if (state_r == S_CLEAR || state_r == S_SCROLL) begin
      ram_we    = 1'b1;
      ram_waddr = swp_addr_r;
      ram_wdata = BLANK_CELL;
    end else begin
      ram_we    = commit && plan.write_cell;
      ram_waddr = put_addr;
      ram_wdata = {attr_r, in_char_code};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc && is_read),
    .raddr (read_addr),
    .rdata (ram_rdata)
  );

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_write_en) begin
      attr_r <= cfg_write_data;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      swp_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          swp_addr_r <= swp_addr_r + ADDR_W'(1);
          if (swp_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && is_read) begin
            rd_ok_r <= read_ok;
            state_r <= S_READ;
          end else if (in_acc) begin
            out_valid_r <= 1'b1;
            cell_r      <= '0;
            cur_out_r   <= plan.cur;
            scrolled_r  <= plan.scroll;
            if (plan.scroll) begin
              swp_addr_r <= top_base;
              swp_end_r  <= top_base + ADDR_W'(COLUMNS - 1);
              state_r    <= S_SCROLL;
            end
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          cell_r      <= rd_ok_r ? ram_rdata : '0;
          cur_out_r   <= cur;
          scrolled_r  <= 1'b0;
          state_r     <= S_IDLE;
        end
        S_SCROLL: begin
          swp_addr_r <= swp_addr_r + ADDR_W'(1);
          if (swp_addr_r == swp_end_r) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = cell_r;
  assign out_cursor_offset = cur_out_r.offset;
  assign out_cursor_col    = cur_out_r.col;
  assign out_cursor_row    = cur_out_r.row;
  assign out_scrolled      = scrolled_r;

endmodule

>>> hw/rtl/tcw_checker.sv
module tcw_checker import tcw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CELL_W-1:0] out_cell_value,
  input logic [OFF_W-1:0]  out_cursor_offset,
  input logic [COL_W-1:0]  out_cursor_col,
  input logic [ROW_W-1:0]  out_cursor_row,
  input logic              out_scrolled
);

  // Screen sweep holds off input straight after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input taken or result shown during screen sweep");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col) < COLUMNS) && (int'(out_cursor_row) < ROWS))
    else $error("cursor off screen");

  // Linear offset agrees with row and column
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_cursor_offset) ==
                  int'(out_cursor_row) * COLUMNS + int'(out_cursor_col))
    else $error("cursor offset mismatch");

  // A scroll leaves the cursor on the last row and carries no cell
  a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> (int'(out_cursor_row) == ROWS - 1) &&
                                  (out_cell_value == '0))
    else $error("scroll result inconsistent");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_value) &&
                               $stable(out_cursor_offset))
    else $error("stalled result beat changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
